[src/pbsl_pkg.sv]
// shared types and constants of the positional byte-set learner
package pbsl_pkg;

  localparam int MaxMsgLenDef = 64;

  localparam int FuncW    = 1;
  localparam int MsgLenW  = 7;
  localparam int PosW     = 6;
  localparam int ByteW    = 8;
  localparam int SetW     = 1 << ByteW;
  localparam int TermW    = 20;
  localparam int NontermW = 12;
  localparam int CountW   = 32;

  localparam logic [FuncW-1:0] FuncLearn = 1'b0;
  localparam logic [FuncW-1:0] FuncEval  = 1'b1;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [MsgLenW-1:0] msg_len;
    logic [PosW-1:0]    position;
    logic [ByteW-1:0]   byte_value;
  } in_t;

  typedef struct packed {
    logic                is_member;
    logic                bad_item;
    logic [TermW-1:0]    terminal_count;
    logic [NontermW-1:0] nonterminal_count;
    logic [CountW-1:0]   true_positives;
    logic [CountW-1:0]   false_negatives;
    logic [CountW-1:0]   messages_at_length;
  } out_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == {CountW{1'b1}}) ? v : v + CountW'(1);
  endfunction

endpackage

[src/pbsl_ram.sv]
// generic single-write, single-read ram with registered read data
module pbsl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/positional_byte_set_learner_unit.sv]
// top level of the positional byte-set learner
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one message
//   byte per request, tagged with its message length and position and with
//   func (learn or evaluate). output channel out_valid_o / out_stall_i /
//   out_data_o returns exactly one result per request, in order.
//   a request is taken at a clock edge with valid high and stall low.
//   a taken request waits in the item register, its result in the output register.
//   throughput: one request per cycle while the output drains; the figure
//   is set by the single read-modify-write of the value-set memory, whose
//   registered read is covered by forwarding from the write port.
//   the output register parts the two sides: a new request is taken while
//   the previous result waits, and the block stalls its input only when a
//   finished item cannot enter the stalled output register.
//   reset clears the seen-length bits and the counters, with the nonterminal
//   count set to one; the set and per-length count memories need no clearing
//   pass, as a count entry is written when its length is first seen.
module positional_byte_set_learner_unit
  import pbsl_pkg::*;
#(
  parameter int MAX_MSG_LEN = MaxMsgLenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int Depth = MAX_MSG_LEN * MAX_MSG_LEN;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LiW   = (MAX_MSG_LEN > 1) ? $clog2(MAX_MSG_LEN) : 1;
  localparam int EntW  = SetW + 1;  // mark bit on top of the 256-bit set

  // handshake and item register
  logic            busy_q, busy_d;
  logic            done;
  logic            accept_in;
  in_t             item_q;
  logic [IdxW-1:0] idx_q;
  logic [LiW-1:0]  li_q;

  // address of the incoming request
  logic [LiW-1:0]  li_s0;
  logic [IdxW-1:0] idx_s0;

  // architectural counters and flags
  logic                length_seen_q [MAX_MSG_LEN];
  logic                cur_new_q, cur_new_d;
  logic [TermW-1:0]    term_q, term_d;
  logic [NontermW-1:0] nterm_q, nterm_d;
  logic [CountW-1:0]   hit_q, hit_d;
  logic [CountW-1:0]   miss_q, miss_d;
  logic                seen_set;

  // memory ports
  logic              set_we;
  logic [EntW-1:0]   set_wdata;
  logic [EntW-1:0]   set_rdata;
  logic              cnt_we;
  logic [CountW-1:0] cnt_wdata;
  logic [CountW-1:0] cnt_rdata;

  // forwarding of a write that lands in the cycle of the read
  logic              fwd_set_q;
  logic [EntW-1:0]   fwd_set_data_q;
  logic              fwd_cnt_q;
  logic [CountW-1:0] fwd_cnt_data_q;

  // item evaluation
  logic              bad;
  logic              seen;
  logic [EntW-1:0]   entry;
  logic [CountW-1:0] cnt_cur;
  logic [SetW-1:0]   onehot;
  logic              hit_bit;
  logic              cur_new_eff;
  logic              is_member;
  logic [CountW-1:0] at_len;

  // output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // item completes when the output register can take its result
  assign done       = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !done;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign busy_d     = accept_in ? 1'b1 : (done ? 1'b0 : busy_q);

  // table address: length row, position column
  assign li_s0  = LiW'(in_data_i.msg_len - MsgLenW'(1));
  assign idx_s0 = IdxW'(IdxW'(li_s0) * IdxW'(MAX_MSG_LEN) + IdxW'(in_data_i.position));

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      item_q         <= in_data_i;
      idx_q          <= idx_s0;
      li_q           <= li_s0;
      fwd_set_data_q <= set_wdata;
      fwd_cnt_data_q <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fwd_set_q   <= 1'b0;
      fwd_cnt_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cur_new_q   <= 1'b0;
      term_q      <= '0;
      nterm_q     <= NontermW'(1);
      hit_q       <= '0;
      miss_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      cur_new_q   <= cur_new_d;
      term_q      <= term_d;
      nterm_q     <= nterm_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      if (accept_in) begin
        fwd_set_q <= set_we && (idx_q == idx_s0);
        fwd_cnt_q <= cnt_we && (li_q == li_s0);
      end
    end
  end

  // seen-length bits, one flop per length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MSG_LEN; i++) begin
        length_seen_q[i] <= 1'b0;
      end
    end else if (seen_set) begin
      length_seen_q[li_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= out_d;
    end
  end

  pbsl_ram #(
    .Width (EntW),
    .Depth (Depth)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (idx_q),
    .wdata_i (set_wdata),
    .re_i    (accept_in),
    .raddr_i (idx_s0),
    .rdata_o (set_rdata)
  );

  pbsl_ram #(
    .Width (CountW),
    .Depth (MAX_MSG_LEN)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (li_q),
    .wdata_i (cnt_wdata),
    .re_i    (accept_in),
    .raddr_i (li_s0),
    .rdata_o (cnt_rdata)
  );

  // read data, taking a write of the previous item to the same entry
  assign entry   = fwd_set_q ? fwd_set_data_q : set_rdata;
  assign cnt_cur = fwd_cnt_q ? fwd_cnt_data_q : cnt_rdata;

  assign bad = (item_q.msg_len == '0)
            || (32'(item_q.msg_len) > 32'(MAX_MSG_LEN))
            || ({1'b0, item_q.position} >= item_q.msg_len);
  assign seen    = !bad && length_seen_q[li_q];
  assign onehot  = SetW'(1) << item_q.byte_value;
  assign hit_bit = entry[item_q.byte_value];

  // read-modify-write of the set entry and the counters
  always_comb begin
    set_we      = 1'b0;
    set_wdata   = {1'b1, entry[SetW-1:0] | onehot};
    cnt_we      = 1'b0;
    cnt_wdata   = sat_inc(cnt_cur);
    seen_set    = 1'b0;
    cur_new_d   = cur_new_q;
    cur_new_eff = cur_new_q;
    term_d      = term_q;
    nterm_d     = nterm_q;
    hit_d       = hit_q;
    miss_d      = miss_q;
    is_member   = 1'b0;
    at_len      = '0;
    if (done && !bad) begin
      if (item_q.func == FuncEval) begin
        if (!seen) begin
          miss_d = sat_inc(miss_q);
        end else begin
          is_member = hit_bit;
          at_len    = cnt_cur;
          if (hit_bit) begin
            hit_d = sat_inc(hit_q);
          end else begin
            miss_d = sat_inc(miss_q);
          end
        end
      end else if (item_q.position == '0 || seen) begin
        at_len = cnt_cur;
        if (item_q.position == '0) begin
          cnt_we = 1'b1;
          if (!seen) begin
            // first message of a new length
            seen_set    = 1'b1;
            cnt_wdata   = CountW'(1);
            nterm_d     = nterm_q + NontermW'(1);
            cur_new_d   = 1'b1;
            cur_new_eff = 1'b1;
          end else begin
            cur_new_d   = 1'b0;
            cur_new_eff = 1'b0;
          end
          at_len = cnt_wdata;
        end
        if (cur_new_eff) begin
          // overwrite the set with the single value
          set_we    = 1'b1;
          set_wdata = {1'b0, onehot};
          term_d    = term_q + TermW'(1);
        end else begin
          is_member = hit_bit;
          if (!hit_bit) begin
            set_we = 1'b1;
            term_d = term_q + TermW'(1);
            if (!entry[SetW]) begin
              nterm_d = nterm_d + NontermW'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_d.is_member          = is_member;
    out_d.bad_item           = bad;
    out_d.terminal_count     = term_d;
    out_d.nonterminal_count  = nterm_d;
    out_d.true_positives     = hit_d;
    out_d.false_negatives    = miss_d;
    out_d.messages_at_length = at_len;
  end

  assign out_valid_d = done ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // a finished item never overwrites a result still held by the receiver
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while the finished item is blocked");

  // memories are written only by a completing, well-formed learn item
  a_write_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (set_we || cnt_we) |-> (done && !bad && item_q.func == FuncLearn))
    else $error("memory write outside a learn completion");

  // a per-length count is written only at the start of a message
  a_cnt_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (item_q.position == '0))
    else $error("count written at nonzero position");
`endif

endmodule
